// ===== hw/rtl/sbsh_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// SHA-256 hasher package
// Round constants, initial hash values and the SHA-256 mixing functions.
// ============================================================================
package sbsh_pkg;

    localparam int WORD_W   = 32;
    localparam int NUM_H    = 8;
    localparam int NUM_RND  = 64;
    localparam int BLK_BITS = 512;

    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [5:0] LAST_RND   = 6'd63;
    localparam logic [1:0] LAST_WORD  = 2'd3;

    localparam logic [WORD_W-1:0] ROUND_K [NUM_RND] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [WORD_W-1:0] INIT_H [NUM_H] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Schedule expansion: rotate 7, rotate 18, shift 3.
    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    // Schedule expansion: rotate 17, rotate 19, shift 10.
    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    // Round function on a: rotate 2, 13, 22.
    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    // Round function on e: rotate 6, 11, 25.
    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

// ===== hw/rtl/sha256_byte_stream_hasher_unit.sv =====
`timescale 1ns / 1ps
// Flow: every 64th accepted byte starts a compression of 64 rounds and a fold, during
// which s_tready is low and no bytes are taken.
// After the final byte the padding is shifted in one byte per cycle (two blocks are
// padded when the length no longer fits in the current one), each padded block is
// compressed, and four digest transfers follow.
// Reset (aresetn low, synchronous) loads the initial hash values and clears counts.
// ============================================================================
// SHA-256 byte stream hasher
// Collects message bytes into a 512-bit shift register that doubles as the
// message schedule window, and runs one shared SHA-256 round per cycle.
// ============================================================================
module sha256_byte_stream_hasher_unit
    import sbsh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // final_byte
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] digest_word
    output logic [1:0]  m_tuser,   // [1:0] word_number
    output logic        m_tlast    // digest_done
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_SEND
    } state_t;

    state_t              state_reg;
    logic [BLK_BITS-1:0] buf_reg;
    logic [5:0]          fill_reg;
    logic [63:0]         bits_reg;
    logic [WORD_W-1:0]   chain_reg [NUM_H];
    logic [WORD_W-1:0]   work_reg [NUM_H];
    logic [5:0]          round_reg;
    logic                pad_reg;
    logic                marker_reg;
    logic                len_ok_reg;
    logic                last_blk_reg;
    logic [1:0]          word_reg;
    logic                m_tvalid_reg;
    logic [63:0]         m_tdata_reg;

    logic [WORD_W-1:0]   w0, w1, w9, w14;
    logic [WORD_W-1:0]   w_new;
    logic [WORD_W-1:0]   t1, t2;
    logic [WORD_W-1:0]   fold_sum [NUM_H];
    logic [5:0]          len_shift;
    logic [7:0]          pad_byte;
    logic                s_xfer;
    logic                m_xfer;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = m_tvalid_reg && m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = word_reg;
    assign m_tlast  = (word_reg == LAST_WORD);

    // Schedule window taps; word 0 is the oldest and sits in the top bits.
    assign w0  = buf_reg[511:480];
    assign w1  = buf_reg[479:448];
    assign w9  = buf_reg[223:192];
    assign w14 = buf_reg[63:32];

    // One SHA-256 round and one schedule expansion step.
    always_comb begin
        w_new = ssig1(w14) + w9 + ssig0(w1) + w0;
        t1    = work_reg[7] + bsig1(work_reg[4])
              + choose(work_reg[4], work_reg[5], work_reg[6])
              + ROUND_K[round_reg] + w0;
        t2    = bsig0(work_reg[0]) + majority(work_reg[0], work_reg[1], work_reg[2]);
    end

    // Chaining update after the last round.
    always_comb begin
        for (int i = 0; i < NUM_H; i++) begin
            fold_sum[i] = chain_reg[i] + work_reg[i];
        end
    end

    // Padding byte: marker, zeros, then the big-endian bit length.
    assign len_shift = {~fill_reg[2:0], 3'b000};
    always_comb begin
        priority if (!marker_reg) begin
            pad_byte = PAD_MARKER;
        end else if (len_ok_reg && (fill_reg >= LEN_POS)) begin
            pad_byte = 8'(bits_reg >> len_shift);
        end else begin
            pad_byte = 8'h00;
        end
    end

    // Sequencer, datapath registers and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            bits_reg     <= '0;
            pad_reg      <= 1'b0;
            marker_reg   <= 1'b0;
            len_ok_reg   <= 1'b0;
            last_blk_reg <= 1'b0;
            word_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            round_reg    <= '0;
            for (int i = 0; i < NUM_H; i++) begin
                chain_reg[i] <= INIT_H[i];
            end
        end else begin
            unique case (state_reg)
                // Take message bytes; a full block starts a compression.
                ST_IDLE: begin
                    if (s_xfer) begin
                        buf_reg  <= {buf_reg[BLK_BITS-9:0], s_tdata};
                        fill_reg <= fill_reg + 6'd1;
                        bits_reg <= bits_reg + 64'd8;
                        if (s_tlast) begin
                            pad_reg    <= 1'b1;
                            marker_reg <= 1'b0;
                        end
                        if (fill_reg == LAST_POS) begin
                            state_reg <= ST_ROUND;
                            round_reg <= '0;
                            for (int i = 0; i < NUM_H; i++) begin
                                work_reg[i] <= chain_reg[i];
                            end
                        end else if (s_tlast) begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                // Shift in one padding byte per cycle.
                ST_PAD: begin
                    buf_reg  <= {buf_reg[BLK_BITS-9:0], pad_byte};
                    fill_reg <= fill_reg + 6'd1;
                    if (!marker_reg) begin
                        marker_reg <= 1'b1;
                    end
                    if (fill_reg == LAST_POS) begin
                        last_blk_reg <= marker_reg && len_ok_reg;
                        // The next block always has room for the length.
                        len_ok_reg   <= 1'b1;
                        state_reg    <= ST_ROUND;
                        round_reg    <= '0;
                        for (int i = 0; i < NUM_H; i++) begin
                            work_reg[i] <= chain_reg[i];
                        end
                    end else if (!marker_reg) begin
                        len_ok_reg <= (fill_reg < LEN_POS);
                    end
                end
                // One compression round per cycle.
                ST_ROUND: begin
                    buf_reg     <= {buf_reg[BLK_BITS-33:0], w_new};
                    work_reg[7] <= work_reg[6];
                    work_reg[6] <= work_reg[5];
                    work_reg[5] <= work_reg[4];
                    work_reg[4] <= work_reg[3] + t1;
                    work_reg[3] <= work_reg[2];
                    work_reg[2] <= work_reg[1];
                    work_reg[1] <= work_reg[0];
                    work_reg[0] <= t1 + t2;
                    round_reg   <= round_reg + 6'd1;
                    if (round_reg == LAST_RND) begin
                        state_reg <= ST_FOLD;
                    end
                end
                // Add the working words into the chaining words.
                ST_FOLD: begin
                    for (int i = 0; i < NUM_H; i++) begin
                        chain_reg[i] <= fold_sum[i];
                    end
                    priority if (last_blk_reg) begin
                        m_tdata_reg  <= {fold_sum[0], fold_sum[1]};
                        m_tvalid_reg <= 1'b1;
                        word_reg     <= '0;
                        state_reg    <= ST_SEND;
                    end else if (pad_reg) begin
                        state_reg <= ST_PAD;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                // Four digest transfers; the chaining words move up two per transfer.
                ST_SEND: begin
                    if (m_xfer) begin
                        if (word_reg == LAST_WORD) begin
                            m_tvalid_reg <= 1'b0;
                            word_reg     <= '0;
                            fill_reg     <= '0;
                            bits_reg     <= '0;
                            pad_reg      <= 1'b0;
                            marker_reg   <= 1'b0;
                            len_ok_reg   <= 1'b0;
                            last_blk_reg <= 1'b0;
                            state_reg    <= ST_IDLE;
                            for (int i = 0; i < NUM_H; i++) begin
                                chain_reg[i] <= INIT_H[i];
                            end
                        end else begin
                            m_tdata_reg <= {chain_reg[2], chain_reg[3]};
                            word_reg    <= word_reg + 2'd1;
                            for (int i = 0; i < NUM_H - 2; i++) begin
                                chain_reg[i] <= chain_reg[i+2];
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // The block never takes bytes while a digest is being delivered.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a digest word is pending");

    // A 64th byte always stops the input for a compression.
    a_full_block_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && (fill_reg == LAST_POS)) |=> (!s_tready && (state_reg == ST_ROUND)))
        else $error("full block did not start a compression");

    // The compression runs its rounds without interruption.
    a_rounds_continue: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_ROUND) && (round_reg != LAST_RND)) |=>
            ((state_reg == ST_ROUND) && (round_reg == $past(round_reg) + 6'd1)))
        else $error("compression rounds interrupted");

    // Digest words leave in order, and the fourth one closes the message.
    a_word_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_xfer && (word_reg != LAST_WORD)) |=>
            (m_tvalid && (word_reg == $past(word_reg) + 2'd1)))
        else $error("digest word order broken");
`endif

endmodule
